// ===== rtl/core/dnsqf_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dnsqf_pkg
// Shared types, constants and the answer record table of the DNS responder.
// ============================================================================
package dnsqf_pkg;

  localparam int MAX_PACKET_BYTES = 128;
  localparam int ANSWER_LEN       = 16;

  localparam int BYTE_W    = 8;
  localparam int POS_W     = 8;
  localparam int LEN_W     = POS_W + 1;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int ANS_IDX_W = $clog2(ANSWER_LEN);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_IP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_TTL = 1'd1;

  localparam logic [CFG_W-1:0] ANSWER_IP_RESET  = 32'd0;
  localparam logic [CFG_W-1:0] ANSWER_TTL_RESET = 32'd300;

  // Header layout and checks.
  localparam logic [POS_W-1:0] POS_FLAGS    = 8'd2;
  localparam logic [POS_W-1:0] POS_QD_HI    = 8'd4;
  localparam logic [POS_W-1:0] POS_QD_LO    = 8'd5;
  localparam logic [POS_W-1:0] POS_AN_HI    = 8'd6;
  localparam logic [POS_W-1:0] POS_AN_LO    = 8'd7;
  localparam logic [POS_W-1:0] POS_NS_HI    = 8'd8;
  localparam logic [POS_W-1:0] POS_AR_LO    = 8'd11;
  localparam logic [POS_W-1:0] HEADER_LEN   = 8'd12;
  localparam logic [POS_W-1:0] POS_MAX      = 8'hFF;
  localparam logic [BYTE_W-1:0] QR_BIT      = 8'h80;
  localparam logic [BYTE_W-1:0] OPCODE_BITS = 8'h78;
  localparam logic [15:0] QDCOUNT_ONE       = 16'h0001;
  localparam logic [15:0] TYPE_A            = 16'h0001;
  localparam logic [LEN_W-1:0] TYPE_TAIL    = 9'd4;
  localparam logic [LEN_W-1:0] LEN_LIMIT    = LEN_W'(MAX_PACKET_BYTES - ANSWER_LEN);

  // Fixed bytes of the answer record.
  localparam logic [BYTE_W-1:0] ANS_PTR_HI  = 8'hC0;
  localparam logic [BYTE_W-1:0] ANS_PTR_LO  = 8'h0C;
  localparam logic [BYTE_W-1:0] ANS_ZERO    = 8'h00;
  localparam logic [BYTE_W-1:0] ANS_ONE     = 8'h01;
  localparam logic [BYTE_W-1:0] ANS_RDLEN   = 8'h04;
  localparam logic [ANS_IDX_W-1:0] ANS_LAST_IDX = ANS_IDX_W'(ANSWER_LEN - 1);

  // Result of parsing one accepted payload beat.
  typedef struct packed {
    logic [BYTE_W-1:0] echo_byte;
    logic              last;
    logic              accept;
  } parse_res_t;

  // Byte k of the appended answer record.
  function automatic logic [BYTE_W-1:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                                    input logic [CFG_W-1:0] ttl,
                                                    input logic [CFG_W-1:0] ip);
    logic [BYTE_W-1:0] b;
    case (idx)
      4'd0:    b = ANS_PTR_HI;
      4'd1:    b = ANS_PTR_LO;
      4'd2:    b = ANS_ZERO;
      4'd3:    b = ANS_ONE;
      4'd4:    b = ANS_ZERO;
      4'd5:    b = ANS_ONE;
      4'd6:    b = ttl[31:24];
      4'd7:    b = ttl[23:16];
      4'd8:    b = ttl[15:8];
      4'd9:    b = ttl[7:0];
      4'd10:   b = ANS_ZERO;
      4'd11:   b = ANS_RDLEN;
      4'd12:   b = ip[31:24];
      4'd13:   b = ip[23:16];
      4'd14:   b = ip[15:8];
      default: b = ip[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/dnsqf_in_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dnsqf_in_if
// Query payload channel: one byte per beat with a last marker.
// ============================================================================
interface dnsqf_in_if;
  logic                         valid;
  logic                         ready;
  logic [dnsqf_pkg::BYTE_W-1:0] in_byte;
  logic                         in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/core/dnsqf_out_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dnsqf_out_if
// Response channel: one byte per beat with last and keep markers.
// ============================================================================
interface dnsqf_out_if;
  logic                         valid;
  logic                         ready;
  logic [dnsqf_pkg::BYTE_W-1:0] out_byte;
  logic                         out_last;
  logic                         keep_frame;

  modport source (output valid, output out_byte, output out_last, output keep_frame,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input keep_frame,
                  output ready);
endinterface

// ===== rtl/core/dnsqf_parse.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dnsqf_parse
// Per-byte header checks, name walk and frame decision on the last byte.
// ============================================================================
module dnsqf_parse (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [dnsqf_pkg::BYTE_W-1:0] in_byte,
  input  logic                         in_last,
  output dnsqf_pkg::parse_res_t        res
);

  logic [dnsqf_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                         hdr_fault_r, hdr_fault_nxt;
  logic [15:0]                  qcount_r, qcount_nxt;
  logic [dnsqf_pkg::BYTE_W-1:0] skip_r, skip_nxt;
  logic                         end_found_r, end_found_nxt;
  logic [dnsqf_pkg::POS_W-1:0]  end_pos_r, end_pos_nxt;
  logic [23:0]                  recent_r, recent_nxt;
  logic [dnsqf_pkg::BYTE_W-1:0] echo;
  logic [dnsqf_pkg::LEN_W-1:0]  len;
  logic [15:0]                  qtype;
  logic                         accept;

  always_comb begin
    echo          = in_byte;
    hdr_fault_nxt = hdr_fault_r;
    qcount_nxt    = qcount_r;
    skip_nxt      = skip_r;
    end_found_nxt = end_found_r;
    end_pos_nxt   = end_pos_r;
    recent_nxt    = {recent_r[15:0], in_byte};

    case (pos_r) inside
      dnsqf_pkg::POS_FLAGS: begin
        if ((in_byte & (dnsqf_pkg::QR_BIT | dnsqf_pkg::OPCODE_BITS)) != '0) begin
          hdr_fault_nxt = 1'b1;
        end
        echo = in_byte | dnsqf_pkg::QR_BIT;
      end
      dnsqf_pkg::POS_QD_HI: qcount_nxt = {in_byte, qcount_r[7:0]};
      dnsqf_pkg::POS_QD_LO: qcount_nxt = {qcount_r[15:8], in_byte};
      dnsqf_pkg::POS_AN_HI, dnsqf_pkg::POS_AN_LO: begin
        if (in_byte != '0) begin
          hdr_fault_nxt = 1'b1;
        end
        echo = (pos_r == dnsqf_pkg::POS_AN_HI) ? qcount_r[15:8] : qcount_r[7:0];
      end
      [dnsqf_pkg::POS_NS_HI:dnsqf_pkg::POS_AR_LO]: begin
        if (in_byte != '0) begin
          hdr_fault_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    // Label walk: a length byte loads the skip count, zero ends the name.
    if (pos_r >= dnsqf_pkg::HEADER_LEN && !end_found_r) begin
      if (skip_r == '0) begin
        if (in_byte == '0) begin
          end_found_nxt = 1'b1;
          end_pos_nxt   = pos_r;
        end else begin
          skip_nxt = in_byte;
        end
      end else begin
        skip_nxt = skip_r - 8'd1;
      end
    end

    pos_nxt = (pos_r == dnsqf_pkg::POS_MAX) ? pos_r : pos_r + 8'd1;

    len    = {1'b0, pos_r} + 9'd1;
    qtype  = recent_r[23:8];
    accept = !hdr_fault_nxt && (qcount_nxt == dnsqf_pkg::QDCOUNT_ONE) && end_found_nxt &&
             (len > ({1'b0, end_pos_nxt} + dnsqf_pkg::TYPE_TAIL)) &&
             (len <= dnsqf_pkg::LEN_LIMIT) && (qtype == dnsqf_pkg::TYPE_A);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && in_last)) begin
      pos_r       <= '0;
      hdr_fault_r <= 1'b0;
      qcount_r    <= '0;
      skip_r      <= '0;
      end_found_r <= 1'b0;
      end_pos_r   <= '0;
      recent_r    <= '0;
    end else if (fire) begin
      pos_r       <= pos_nxt;
      hdr_fault_r <= hdr_fault_nxt;
      qcount_r    <= qcount_nxt;
      skip_r      <= skip_nxt;
      end_found_r <= end_found_nxt;
      end_pos_r   <= end_pos_nxt;
      recent_r    <= recent_nxt;
    end
  end

  assign res.echo_byte = echo;
  assign res.last      = in_last;
  assign res.accept    = accept;

endmodule

// ===== rtl/core/dnsqf_emit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dnsqf_emit
// Output register and answer record sequencer.
// ============================================================================
module dnsqf_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  dnsqf_pkg::parse_res_t       res,
  input  logic [dnsqf_pkg::CFG_W-1:0] answer_ip,
  input  logic [dnsqf_pkg::CFG_W-1:0] answer_ttl,
  output logic                        take_ok,
  dnsqf_out_if.source                 out_ch
);

  logic                            vld_r, vld_nxt;
  logic [dnsqf_pkg::BYTE_W-1:0]    byte_r, byte_nxt;
  logic                            last_r, last_nxt;
  logic                            keep_r, keep_nxt;
  logic                            ans_act_r, ans_act_nxt;
  logic [dnsqf_pkg::ANS_IDX_W-1:0] ans_idx_r, ans_idx_nxt;
  logic                            drain;
  logic                            idx_end;

  assign drain   = vld_r && out_ch.ready;
  assign idx_end = (ans_idx_r == dnsqf_pkg::ANS_LAST_IDX);
  assign take_ok = !ans_act_r && (!vld_r || out_ch.ready);

  always_comb begin
    vld_nxt     = vld_r;
    byte_nxt    = byte_r;
    last_nxt    = last_r;
    keep_nxt    = keep_r;
    ans_act_nxt = ans_act_r;
    ans_idx_nxt = ans_idx_r;
    if (fire) begin
      vld_nxt  = 1'b1;
      byte_nxt = res.echo_byte;
      keep_nxt = 1'b0;
      if (res.last && res.accept) begin
        last_nxt    = 1'b0;
        ans_act_nxt = 1'b1;
        ans_idx_nxt = '0;
      end else begin
        last_nxt = res.last;
      end
    end else if (drain && ans_act_r) begin
      byte_nxt    = dnsqf_pkg::answer_byte(ans_idx_r, answer_ttl, answer_ip);
      last_nxt    = idx_end;
      keep_nxt    = idx_end;
      ans_act_nxt = !idx_end;
      ans_idx_nxt = ans_idx_r + 4'd1;
    end else if (drain) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      ans_act_r <= 1'b0;
      ans_idx_r <= '0;
    end else begin
      vld_r     <= vld_nxt;
      ans_act_r <= ans_act_nxt;
      ans_idx_r <= ans_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    keep_r <= keep_nxt;
  end

  assign out_ch.valid      = vld_r;
  assign out_ch.out_byte   = byte_r;
  assign out_ch.out_last   = last_r;
  assign out_ch.keep_frame = keep_r;

endmodule

// ===== rtl/core/dns_query_filter_responder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dns_query_filter_responder
// Echoes a DNS query as a response and appends a fixed A record when valid.
// ============================================================================
//
//  Channel   Dir  Handshake        Beat contents
//  in_ch     in   valid / ready    in_byte, in_last
//  out_ch    out  valid / ready    out_byte, out_last, keep_frame
//  cfg       in   cfg_we           cfg_index, cfg_wdata (answer IP, answer TTL)
//
// Each payload beat's rewritten echo is loaded into the output register at
// the accepting edge and offered in the next cycle, so a stream runs at one
// beat per cycle while the output is not stalled and no answer is being sent.
// A frame that passes the checks is followed by 16 answer beats; the input
// waits while they are sent through the single output register.
// Reset is synchronous and active low: it clears the frame state, empties the
// output register and loads the TTL register with 300 and the IP with zero.
// A stall on the output holds the output register and back-pressures input.
//
module dns_query_filter_responder (
  input  logic                            clk,
  input  logic                            rst_n,
  dnsqf_in_if.sink                        in_ch,
  dnsqf_out_if.source                     out_ch,
  input  logic                            cfg_we,
  input  logic [dnsqf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dnsqf_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [dnsqf_pkg::CFG_W-1:0] answer_ip_r;
  logic [dnsqf_pkg::CFG_W-1:0] answer_ttl_r;
  dnsqf_pkg::parse_res_t       res;
  logic                        take_ok;
  logic                        fire;

  // Configuration registers. The user must write them only while the block is
  // idle; the block does not enforce it. The answer sequencer reads them directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      answer_ip_r  <= dnsqf_pkg::ANSWER_IP_RESET;
      answer_ttl_r <= dnsqf_pkg::ANSWER_TTL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dnsqf_pkg::CFG_ANSWER_IP:  answer_ip_r  <= cfg_wdata;
        dnsqf_pkg::CFG_ANSWER_TTL: answer_ttl_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A beat is accepted whenever the output register can take its echo and
  // no answer record is being sent.
  assign in_ch.ready = take_ok;
  assign fire        = in_ch.valid && take_ok;

  dnsqf_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_byte (in_ch.in_byte),
    .in_last (in_ch.in_last),
    .res     (res)
  );

  dnsqf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .res        (res),
    .answer_ip  (answer_ip_r),
    .answer_ttl (answer_ttl_r),
    .take_ok    (take_ok),
    .out_ch     (out_ch)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the DNS query responder.
// ============================================================================
// Query frames are streamed into the block one byte per beat. A behavioral
// model inside the bench tracks the header checks, the name walk and the
// final accept decision. From that it queues the expected response beats:
// the rewritten echo, and the 16-byte answer record for accepted frames.
// Each response beat is checked against the oldest queued beat. Both sides
// idle at random. Directed frames cover header faults, short and long frames
// and compression marks, and one phase holds the output off long enough to
// stall the input. A short run of random frames follows, mostly well formed.
// ============================================================================
module tb_top;

  localparam int HOLD_CYCLES   = 200;  // long receiver hold-off
  localparam int DRAIN_TAIL    = 4;    // single output register, small margin
  localparam int RANDOM_BYTES  = 50;
  localparam int RESP_REC_BITS = dnsqf_pkg::ANSWER_LEN * dnsqf_pkg::BYTE_W;

  // Shapes of random query frames. Clean frames are the bulk of the traffic.
  typedef enum int {
    SHAPE_CLEAN     = 0,
    SHAPE_HDR_FLIP  = 1,
    SHAPE_BAD_TYPE  = 2,
    SHAPE_TRUNCATE  = 3,
    SHAPE_NOISE     = 4,
    SHAPE_OVERSIZE  = 5,
    SHAPE_COMP_MARK = 6,
    SHAPE_QDCOUNT   = 7
  } frame_shape_t;

  typedef logic [dnsqf_pkg::BYTE_W-1:0] byte_t;

  // One expected response beat.
  typedef struct {
    byte_t data;
    logic  last;
    logic  keep;
  } reply_beat_t;

  logic clk;
  logic rst_n;
  logic                            cfg_we;
  logic [dnsqf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dnsqf_pkg::CFG_W-1:0]     cfg_wdata;

  dnsqf_in_if  in_ch ();
  dnsqf_out_if out_ch ();

  dns_query_filter_responder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Expected response beats, oldest first.
  reply_beat_t reply_q[$];
  // Query frame being assembled by the directed and random tests.
  byte_t frame_q[$];

  int  err_count  = 0;
  int  bytes_sent = 0;
  bit  calm       = 1'b0;  // when set, neither side idles
  bit  hold_req   = 1'b0;  // asks the receiver for one long hold-off

  // Model copy of the registers.
  logic [dnsqf_pkg::CFG_W-1:0] ans_ip;
  logic [dnsqf_pkg::CFG_W-1:0] ans_ttl;

  // Model copy of the per-frame parse state.
  logic [dnsqf_pkg::POS_W-1:0] q_pos;
  logic                        q_hdr_bad;
  logic [15:0]                 q_qdcount;
  logic [dnsqf_pkg::POS_W-1:0] q_skip;
  logic                        q_name_done;
  logic [dnsqf_pkg::POS_W-1:0] q_name_end;
  logic [31:0]                 q_tail;

  // --------------------------------------------------------------------------
  // Clock and time limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The slowest correct run is far below this, even with every frame
  // accepted and every response beat waiting out a long receiver stall.
  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model of the block
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic clear_query_state();
    q_pos       = '0;
    q_hdr_bad   = 1'b0;
    q_qdcount   = '0;
    q_skip      = '0;
    q_name_done = 1'b0;
    q_name_end  = '0;
    q_tail      = '0;
  endtask

  task automatic push_reply(input byte_t data, input logic last, input logic keep);
    reply_q.push_back('{data: data, last: last, keep: keep});
  endtask

  // Takes one accepted query byte and queues the response beats it causes.
  task automatic absorb_query_byte(input byte_t b, input logic last);
    logic [dnsqf_pkg::POS_W-1:0] at;
    byte_t                       echo;
    logic [15:0]                 qtype;
    logic [RESP_REC_BITS-1:0]    rec;
    int                          len;
    bit                          ok;
    at     = q_pos;
    echo   = b;
    q_tail = {q_tail[23:0], b};

    // Header: the flags byte gets QR set, the answer count is replaced by
    // the question count, and all checked fields must be zero.
    if (at == dnsqf_pkg::POS_FLAGS) begin
      if ((b & (dnsqf_pkg::QR_BIT | dnsqf_pkg::OPCODE_BITS)) != '0) q_hdr_bad = 1'b1;
      echo = b | dnsqf_pkg::QR_BIT;
    end else if (at == dnsqf_pkg::POS_QD_HI) begin
      q_qdcount[15:8] = b;
    end else if (at == dnsqf_pkg::POS_QD_LO) begin
      q_qdcount[7:0] = b;
    end else if (at == dnsqf_pkg::POS_AN_HI || at == dnsqf_pkg::POS_AN_LO) begin
      if (b != '0) q_hdr_bad = 1'b1;
      echo = (at == dnsqf_pkg::POS_AN_HI) ? q_qdcount[15:8] : q_qdcount[7:0];
    end else if (at >= dnsqf_pkg::POS_NS_HI && at <= dnsqf_pkg::POS_AR_LO) begin
      if (b != '0) q_hdr_bad = 1'b1;
    end

    // Name walk: every length byte, compression marks included, skips that
    // many bytes; a zero length byte ends the name.
    if (at >= dnsqf_pkg::HEADER_LEN && !q_name_done) begin
      if (q_skip == '0) begin
        if (b == '0) begin
          q_name_done = 1'b1;
          q_name_end  = at;
        end else begin
          q_skip = b;
        end
      end else begin
        q_skip = q_skip - 8'd1;
      end
    end

    if (q_pos != dnsqf_pkg::POS_MAX) q_pos = q_pos + 8'd1;

    if (!last) begin
      push_reply(echo, 1'b0, 1'b0);
    end else begin
      // The position saturates, so a very long frame reads as 256 bytes.
      len   = int'(at) + 1;
      qtype = q_tail[31:16];
      ok    = !q_hdr_bad && q_qdcount == dnsqf_pkg::QDCOUNT_ONE && q_name_done &&
              len > int'(q_name_end) + 4 && len <= int'(dnsqf_pkg::LEN_LIMIT) &&
              qtype == dnsqf_pkg::TYPE_A;
      clear_query_state();
      push_reply(echo, !ok, 1'b0);
      if (ok) begin
        rec = {dnsqf_pkg::ANS_PTR_HI, dnsqf_pkg::ANS_PTR_LO, dnsqf_pkg::ANS_ZERO,
               dnsqf_pkg::ANS_ONE, dnsqf_pkg::ANS_ZERO, dnsqf_pkg::ANS_ONE,
               ans_ttl, dnsqf_pkg::ANS_ZERO, dnsqf_pkg::ANS_RDLEN, ans_ip};
        for (int k = 0; k < dnsqf_pkg::ANSWER_LEN; k++) begin
          push_reply(rec[RESP_REC_BITS-1-dnsqf_pkg::BYTE_W*k -: dnsqf_pkg::BYTE_W],
                     k == dnsqf_pkg::ANSWER_LEN - 1, k == dnsqf_pkg::ANSWER_LEN - 1);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Response side: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : reply_ready_gen
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Every response beat is compared with the oldest expected beat.
  always @(posedge clk) begin : check_reply_beat
    reply_beat_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (reply_q.size() == 0) begin
        $error("unexpected response beat: out_byte %02h out_last %0b keep_frame %0b",
               out_ch.out_byte, out_ch.out_last, out_ch.keep_frame);
        err_count++;
      end else begin
        want = reply_q.pop_front();
        if (out_ch.out_byte !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_ch.out_byte);
          err_count++;
        end
        if (out_ch.out_last !== want.last) begin
          $error("out_last: expected %0b, got %0b", want.last, out_ch.out_last);
          err_count++;
        end
        if (out_ch.keep_frame !== want.keep) begin
          $error("keep_frame: expected %0b, got %0b", want.keep, out_ch.keep_frame);
          err_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Query side
  // --------------------------------------------------------------------------
  // Offers one byte and waits for the beat to be taken. Valid stays high
  // afterwards so the next call can follow without a bubble.
  task automatic send_byte(input byte_t b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    absorb_query_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  // Drops valid and waits until every expected beat has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_answer_reg(input logic [dnsqf_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [dnsqf_pkg::CFG_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == dnsqf_pkg::CFG_ANSWER_IP) ans_ip = value;
    else                                 ans_ttl = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Builds a well-formed A query: clean header, nlabels labels of random
  // length, the zero label, extra filler bytes, then type A and a class.
  task automatic build_query(input int nlabels, input int max_label, input int extra);
    int n;
    frame_q.delete();
    frame_q.push_back(byte_t'($urandom));
    frame_q.push_back(byte_t'($urandom));
    frame_q.push_back(byte_t'($urandom) & ~(dnsqf_pkg::QR_BIT | dnsqf_pkg::OPCODE_BITS));
    frame_q.push_back(byte_t'($urandom));
    frame_q.push_back(dnsqf_pkg::QDCOUNT_ONE[15:8]);
    frame_q.push_back(dnsqf_pkg::QDCOUNT_ONE[7:0]);
    repeat (6) frame_q.push_back(8'h00);
    repeat (nlabels) begin
      n = $urandom_range(1, max_label);
      frame_q.push_back(byte_t'(n));
      repeat (n) frame_q.push_back(byte_t'($urandom));
    end
    frame_q.push_back(8'h00);
    repeat (extra) frame_q.push_back(byte_t'($urandom));
    frame_q.push_back(dnsqf_pkg::TYPE_A[15:8]);
    frame_q.push_back(dnsqf_pkg::TYPE_A[7:0]);
    frame_q.push_back(byte_t'($urandom));
    frame_q.push_back(byte_t'($urandom));
  endtask

  // Grows the frame with filler bytes just ahead of the type and class.
  task automatic pad_to(input int target);
    while (frame_q.size() < target) begin
      frame_q.insert(frame_q.size() - 4, byte_t'($urandom));
    end
  endtask

  task automatic truncate_to(input int target);
    while (frame_q.size() > target) void'(frame_q.pop_back());
  endtask

  task automatic send_with_byte(input int idx, input byte_t value);
    build_query(0, 1, 0);
    frame_q[idx] = value;
    send_frame();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // A clean query with the register values from reset: TTL 300, address 0.
  task automatic test_reset_answer();
    build_query(1, 3, 0);
    send_frame();
  endtask

  // Both registers at their extremes. Random traffic covers middle values.
  task automatic test_answer_registers();
    write_answer_reg(dnsqf_pkg::CFG_ANSWER_IP, 32'hFFFF_FFFF);
    write_answer_reg(dnsqf_pkg::CFG_ANSWER_TTL, 32'h0000_0000);
    build_query(1, 3, 0);
    send_frame();
    write_answer_reg(dnsqf_pkg::CFG_ANSWER_IP, 32'h0000_0000);
    write_answer_reg(dnsqf_pkg::CFG_ANSWER_TTL, 32'hFFFF_FFFF);
    build_query(1, 3, 0);
    send_frame();
  endtask

  // Each header check on its own. The flags byte with only its low bits set
  // must still pass; QR and any single opcode bit must fail.
  task automatic test_header_checks();
    int    k;
    byte_t one_bit;
    send_with_byte(dnsqf_pkg::POS_FLAGS, 8'h07);
    send_with_byte(dnsqf_pkg::POS_FLAGS, dnsqf_pkg::QR_BIT);
    do begin
      k = $urandom_range(0, dnsqf_pkg::BYTE_W - 1);
    end while (!dnsqf_pkg::OPCODE_BITS[k]);
    one_bit    = '0;
    one_bit[k] = 1'b1;
    send_with_byte(dnsqf_pkg::POS_FLAGS, one_bit);
    send_with_byte(dnsqf_pkg::POS_QD_HI, 8'h01);  // question count 0x0101, echoed as such
    send_with_byte(dnsqf_pkg::POS_QD_LO, 8'h02);
    // A nonzero answer count, then a nonzero authority or additional count.
    send_with_byte($urandom_range(dnsqf_pkg::POS_AN_HI, dnsqf_pkg::POS_AN_LO),
                   byte_t'($urandom_range(1, 255)));
    send_with_byte($urandom_range(dnsqf_pkg::POS_NS_HI, dnsqf_pkg::POS_AR_LO),
                   byte_t'($urandom_range(1, 255)));
    // Wrong type: AAAA.
    build_query(0, 1, 0);
    frame_q[frame_q.size() - 3] = 8'h1C;
    send_frame();
  endtask

  // Frames that end too early: one byte, one byte short of a full type and
  // class after the zero label, and inside the name.
  task automatic test_short_frames();
    frame_q.delete();
    frame_q.push_back(8'hFF);
    send_frame();
    build_query(0, 1, 0);
    truncate_to(dnsqf_pkg::HEADER_LEN + 4);
    send_frame();
    build_query(2, 8, 0);
    truncate_to(dnsqf_pkg::HEADER_LEN + 3);
    send_frame();
  endtask

  // One byte over the length limit, and a compression mark walked as a plain
  // length byte.
  task automatic test_length_and_marks();
    build_query(2, 6, 0);
    pad_to(int'(dnsqf_pkg::LEN_LIMIT) + 1);
    send_frame();
    // The mark swallows the type and class, so the name never ends.
    build_query(0, 1, 0);
    frame_q[dnsqf_pkg::HEADER_LEN] = 8'hC0;
    send_frame();
  endtask

  // The receiver holds off for a long stretch while the longest frame that
  // still fits comes back to back; filler bytes between the question and the
  // type are allowed, so it is accepted. The output register fills and the
  // input has to stall.
  task automatic test_output_hold();
    wait_drained();
    calm     = 1'b1;
    hold_req = 1'b1;
    build_query(2, 6, 0);
    pad_to(int'(dnsqf_pkg::LEN_LIMIT));
    send_frame();
    calm = 1'b0;
  endtask

  // Mostly clean queries with random content, mixed with damaged frames and
  // noise. The registers change every second frame.
  task automatic test_random_traffic();
    int           start;
    int           frame_no;
    int           r;
    frame_shape_t shape;
    start    = bytes_sent;
    frame_no = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      frame_no++;
      if (frame_no % 2 == 0) begin
        r = $urandom_range(0, 3);
        write_answer_reg(dnsqf_pkg::CFG_ANSWER_IP,
                         (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom);
        write_answer_reg(dnsqf_pkg::CFG_ANSWER_TTL, $urandom);
      end
      calm  = ($urandom_range(0, 4) == 0);
      r     = $urandom_range(0, 19);
      shape = (r < 13) ? SHAPE_CLEAN : frame_shape_t'(r - 12);
      build_query($urandom_range(0, 3), $urandom_range(1, 8),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      case (shape)
        SHAPE_HDR_FLIP: begin
          r = $urandom_range(dnsqf_pkg::POS_FLAGS, dnsqf_pkg::POS_AR_LO);
          frame_q[r] = frame_q[r] ^ byte_t'($urandom_range(1, 255));
        end
        SHAPE_BAD_TYPE: begin
          frame_q[frame_q.size() - 4] = byte_t'($urandom);
          frame_q[frame_q.size() - 3] = byte_t'($urandom);
        end
        SHAPE_TRUNCATE: begin
          truncate_to($urandom_range(1, frame_q.size() - 1));
        end
        SHAPE_NOISE: begin
          frame_q.delete();
          repeat ($urandom_range(1, 40)) frame_q.push_back(byte_t'($urandom));
        end
        SHAPE_OVERSIZE: begin
          pad_to($urandom_range(int'(dnsqf_pkg::LEN_LIMIT) - 10,
                                int'(dnsqf_pkg::LEN_LIMIT) + 15));
        end
        SHAPE_COMP_MARK: begin
          frame_q[dnsqf_pkg::HEADER_LEN] = byte_t'($urandom_range(8'hC0, 8'hFF));
        end
        SHAPE_QDCOUNT: begin
          frame_q[dnsqf_pkg::POS_QD_HI] = byte_t'($urandom_range(0, 1));
          frame_q[dnsqf_pkg::POS_QD_LO] = byte_t'($urandom_range(0, 3));
        end
        default: begin
        end
      endcase
      send_frame();
    end
    calm = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    ans_ip        = dnsqf_pkg::ANSWER_IP_RESET;
    ans_ttl       = dnsqf_pkg::ANSWER_TTL_RESET;
    clear_query_state();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_answer();
    test_answer_registers();
    test_header_checks();
    test_short_frames();
    test_length_and_marks();
    test_output_hold();
    test_random_traffic();

    wait_drained();
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
